[sv/sdh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step detector package
// Shared widths, register indexes, command codes and status types.
// ----------------------------------------------------------------------------
package sdh_pkg;

    // Field widths fixed by the sample format.
    localparam int ACCEL_IN_BITS  = 15;
    localparam int CFG_BITS       = 14;
    localparam int CFG_INDEX_BITS = 2;
    localparam int TOTAL_BITS     = 24;

    // Sum of three squares of 15-bit magnitudes stays below 2^30.
    localparam int RAD_BITS  = 30;
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 2;

    // Gravity, 9.8 m/s^2 at 1/256 m/s^2 per LSB.
    localparam logic [ROOT_BITS-1:0] GRAVITY_LSB = 15'd2509;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_LEVEL  = 2'd1;

    // Register reset values.
    localparam logic [CFG_BITS-1:0] STEP_THRESHOLD_RESET = 14'd512;
    localparam logic [CFG_BITS-1:0] RELEASE_LEVEL_RESET  = 14'd358;

    // Input command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Default values for the top-level parameters.
    localparam int COUNT_BITS_DEF = 24;
    localparam int ACCEL_BITS_DEF = 16;

    typedef logic signed [ACCEL_IN_BITS-1:0] accel_t;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

[sv/sdh_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step detector channels
// Valid/ready channels for acceleration samples and step results.
// ----------------------------------------------------------------------------

// Sample channel: one command or acceleration sample per transfer.
interface sdh_in_if;
    import sdh_pkg::*;

    logic   valid;
    logic   ready;
    logic   cmd;
    accel_t accel_x;
    accel_t accel_y;
    accel_t accel_z;

    modport source (output valid, output cmd, output accel_x, output accel_y,
                    output accel_z, input ready);
    modport sink   (input valid, input cmd, input accel_x, input accel_y,
                    input accel_z, output ready);
endinterface

// Result channel: one step flag and total per transfer.
interface sdh_out_if;
    import sdh_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  step_seen;
    logic [TOTAL_BITS-1:0] step_total;

    modport source (output valid, output step_seen, output step_total, input ready);
    modport sink   (input valid, input step_seen, input step_total, output ready);
endinterface

[sv/sdh_sumsq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sum of squares unit
// One shared squarer accumulates x*x + y*y + z*z, one axis at a time.
// ----------------------------------------------------------------------------
module sdh_sumsq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  sdh_pkg::accel_t               accel_x,
    input  sdh_pkg::accel_t               accel_y,
    input  sdh_pkg::accel_t               accel_z,
    output logic [sdh_pkg::RAD_BITS-1:0]  sum,
    output sdh_pkg::unit_stat_t           stat
);
    import sdh_pkg::*;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [1:0]               idx_reg, idx_next;
    accel_t                   x_reg, x_next;
    accel_t                   y_reg, y_next;
    accel_t                   z_reg, z_next;
    logic [RAD_BITS-1:0]      acc_reg, acc_next;
    accel_t                   field;
    logic [ACCEL_IN_BITS-1:0] operand;
    logic [RAD_BITS-1:0]      square;

    // Pick the axis for this pass and take its magnitude.
    always_comb
    begin
        case (idx_reg)
            AXIS_X:  field = x_reg;
            AXIS_Y:  field = y_reg;
            default: field = z_reg;
        endcase
        operand = field[ACCEL_IN_BITS-1] ? (~field + 1'b1) : field;
        square  = {{(RAD_BITS-ACCEL_IN_BITS){1'b0}}, operand}
                * {{(RAD_BITS-ACCEL_IN_BITS){1'b0}}, operand};
    end

    // Sequencer: latch the sample, then one square per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        acc_next  = acc_reg;
        if (busy_reg)
        begin
            acc_next = acc_reg + square;
            idx_next = idx_reg + 2'd1;
            if (idx_reg == AXIS_Z)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            idx_next  = AXIS_X;
            x_next    = accel_x;
            y_next    = accel_y;
            z_next    = accel_z;
            acc_next  = '0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= AXIS_X;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        acc_reg <= acc_next;
    end

    assign sum       = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[sv/sdh_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root unit
// Restoring digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module sdh_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sdh_pkg::RAD_BITS-1:0]  radicand,
    output logic [sdh_pkg::ROOT_BITS-1:0] root,
    output sdh_pkg::unit_stat_t           stat
);
    import sdh_pkg::*;

    localparam int CNT_BITS = $clog2(ROOT_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(ROOT_BITS - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [RAD_BITS-1:0]  rad_reg, rad_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0] q_reg, q_next;
    logic [REM_BITS-1:0]  rem_shift;
    logic [REM_BITS-1:0]  trial;
    logic                 fits;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb
    begin
        rem_shift = {rem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
        trial     = {q_reg, 2'b01};
        fits      = (rem_shift >= trial);
    end

    // Sequencer for the root iterations.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_next = fits ? (rem_shift - trial) : rem_shift;
            q_next   = {q_reg[ROOT_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            q_next    = '0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign root      = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[sv/step_detector_hysteresis_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step detector with hysteresis
// Counts steps from the deviation of acceleration magnitude from gravity.
// ----------------------------------------------------------------------------
// An acceleration sample passes from its input transfer through the shared
// squarer, which accumulates the sum of squares, then the bit-serial square
// root (one root bit per cycle), and then the handoffs and the final threshold
// decision before the block is ready again. A clear command skips both units.
// The result is held in an output register, and the input side is ready again
// once the result is loaded there; a result that is not yet taken holds back
// only the decision of the following item. Configuration writes take effect
// at the clock edge of the write.
// ----------------------------------------------------------------------------
module step_detector_hysteresis_unit #(
    parameter int COUNT_BITS = sdh_pkg::COUNT_BITS_DEF,
    parameter int ACCEL_BITS = sdh_pkg::ACCEL_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sdh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sdh_pkg::CFG_BITS-1:0]       cfg_data,
    sdh_in_if.sink                             in_ch,
    sdh_out_if.source                          out_ch
);
    import sdh_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_ROOT   = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam int DEV_BITS = ACCEL_BITS - 1;
    localparam int CMP_BITS = (DEV_BITS > ROOT_BITS) ? DEV_BITS : ROOT_BITS;
    localparam int TOT_WIDE = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;

    logic [1:0]            state_reg, state_next;
    logic                  cmd_reg, cmd_next;
    logic [CFG_BITS-1:0]   thr_reg, thr_next;
    logic [CFG_BITS-1:0]   rel_reg, rel_next;
    logic [DEV_BITS-1:0]   prev_reg, prev_next;
    logic                  armed_reg, armed_next;
    logic [COUNT_BITS-1:0] raw_reg, raw_next;
    logic [COUNT_BITS-1:0] offset_reg, offset_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_seen_reg, out_seen_next;
    logic [TOTAL_BITS-1:0] out_total_reg, out_total_next;

    logic                  in_xfer;
    logic                  out_free;
    logic [RAD_BITS-1:0]   sum;
    logic [ROOT_BITS-1:0]  mag;
    unit_stat_t            sq_stat;
    unit_stat_t            rt_stat;
    logic [ROOT_BITS-1:0]  dev_full;
    logic [CMP_BITS-1:0]   dev_wide;
    logic [CMP_BITS-1:0]   dev_max;
    logic [CMP_BITS-1:0]   dev_sat;
    logic [CMP_BITS-1:0]   prev_wide;
    logic [CMP_BITS-1:0]   thr_wide;
    logic [CMP_BITS-1:0]   rel_wide;
    logic                  step_hit;
    logic                  release_hit;
    logic [COUNT_BITS-1:0] diff;
    logic [TOT_WIDE-1:0]   total_wide;

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // Shared squarer and square root units.
    sdh_sumsq u_sumsq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_xfer && (in_ch.cmd == CMD_SAMPLE)),
        .accel_x (in_ch.accel_x),
        .accel_y (in_ch.accel_y),
        .accel_z (in_ch.accel_z),
        .sum     (sum),
        .stat    (sq_stat)
    );

    sdh_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_stat.done),
        .radicand (sum),
        .root     (mag),
        .stat     (rt_stat)
    );

    // Deviation from gravity, saturated, and the hysteresis decision.
    always_comb
    begin
        dev_full    = (mag >= GRAVITY_LSB) ? (mag - GRAVITY_LSB) : (GRAVITY_LSB - mag);
        dev_wide    = CMP_BITS'(dev_full);
        dev_max     = CMP_BITS'({DEV_BITS{1'b1}});
        dev_sat     = (dev_wide > dev_max) ? dev_max : dev_wide;
        prev_wide   = CMP_BITS'(prev_reg);
        thr_wide    = CMP_BITS'(thr_reg);
        rel_wide    = CMP_BITS'(rel_reg);
        step_hit    = (dev_sat > thr_wide) && (prev_wide <= thr_wide) && !armed_reg;
        release_hit = (dev_sat <= rel_wide) && (prev_wide > rel_wide);
    end

    // Sequencer, step state and output register.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        prev_next      = prev_reg;
        armed_next     = armed_reg;
        raw_next       = raw_reg;
        offset_next    = offset_reg;
        out_valid_next = out_valid_reg;
        out_seen_next  = out_seen_reg;
        out_total_next = out_total_reg;
        diff           = '0;
        total_wide     = '0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next   = in_ch.cmd;
                    state_next = (in_ch.cmd == CMD_CLEAR) ? ST_EMIT : ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (sq_stat.done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rt_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_seen_next = 1'b0;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        offset_next = raw_reg;
                    end
                    else
                    begin
                        prev_next = dev_sat[DEV_BITS-1:0];
                        if (step_hit)
                        begin
                            armed_next    = 1'b1;
                            out_seen_next = 1'b1;
                            raw_next      = raw_reg + 1'b1;
                        end
                        else if (release_hit)
                        begin
                            armed_next = 1'b0;
                        end
                    end
                    diff           = raw_next - offset_next;
                    total_wide     = TOT_WIDE'(diff);
                    out_total_next = total_wide[TOTAL_BITS-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_comb
    begin
        thr_next = thr_reg;
        rel_next = rel_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_THRESHOLD: thr_next = cfg_data;
                REG_RELEASE_LEVEL:  rel_next = cfg_data;
                default:
                begin
                    thr_next = thr_reg;
                end
            endcase
        end
    end

    // Control and step state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_SAMPLE;
            thr_reg       <= STEP_THRESHOLD_RESET;
            rel_reg       <= RELEASE_LEVEL_RESET;
            prev_reg      <= '0;
            armed_reg     <= 1'b0;
            raw_reg       <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_seen_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            thr_reg       <= thr_next;
            rel_reg       <= rel_next;
            prev_reg      <= prev_next;
            armed_reg     <= armed_next;
            raw_reg       <= raw_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
            out_seen_reg  <= out_seen_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_total_reg <= out_total_next;
    end

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.step_seen  = out_seen_reg;
    assign out_ch.step_total = out_total_reg;

`ifndef SYNTHESIS
    // An accepted item always starts a pass through the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != ST_IDLE))
        else $error("accepted item did not leave idle");

    // The squarer only runs while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.busy |-> (state_reg == ST_SQUARE))
        else $error("squarer busy outside its state");

    // The root unit only runs while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        rt_stat.busy |-> (state_reg == ST_ROOT))
        else $error("root unit busy outside its state");

    // A pending step flag means the detector is armed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_seen_reg) |-> armed_reg)
        else $error("step reported while not armed");

    // The raw count only moves together with a reported step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (raw_reg != $past(raw_reg)) |-> (out_valid_reg && out_seen_reg))
        else $error("raw count changed without a step");
`endif

endmodule
